/* sv/civil_date_serial_converter_core_defines.svh */
// Assertion macros for the civil date / serial day converter.
// Included by RTL files that carry concurrent checks; no other dependencies.
`ifndef CIVIL_DATE_SERIAL_CONVERTER_CORE_DEFINES_SVH
`define CIVIL_DATE_SERIAL_CONVERTER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, disabled during reset
`define CDSC_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define CDSC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define CDSC_ASSERT_NOW(label, clk, rstn, ante, cons, msg)
`define CDSC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)

`endif

`endif

/* sv/cdsc_pkg.sv */
// Shared types, calendar constants and constant-divisor helpers for the
// civil date / serial day converter. No dependencies.
package cdsc_pkg;

    // Beat layout
    localparam int unsigned YEAR_W    = 14;
    localparam int unsigned MONTH_W   = 4;
    localparam int unsigned DAY_W     = 5;
    localparam int unsigned SERIAL_W  = 23;
    localparam int unsigned WDAY_W    = 3;
    localparam int unsigned MLEN_W    = 5;
    localparam int unsigned S_TDATA_W = 48;
    localparam int unsigned M_TDATA_W = 56;

    // Pipeline depth: eleven work stages plus the output register
    localparam int unsigned NSTAGE = 12;

    // Calendar constants
    localparam int unsigned YEAR_MAX    = 9999;
    localparam int unsigned EPOCH_SHIFT = 719468;
    localparam int unsigned ERA_DAYS    = 146097;
    localparam int unsigned EPOCH_BIAS  = EPOCH_SHIFT + ERA_DAYS;
    localparam int unsigned WDAY_BIAS   = 3 + 7 * 200000;
    localparam logic signed [SERIAL_W-1:0] SERIAL_MIN = -23'sd719528;
    localparam logic signed [SERIAL_W-1:0] SERIAL_MAX = 23'sd2932896;

    typedef enum logic {
        REQ_DATE_TO_SERIAL = 1'b0,
        REQ_SERIAL_TO_DATE = 1'b1
    } req_type_t;

    // Reciprocal multipliers: q = (x * M) >> K, exact over each input width, but div100 keeps 8 bits
    localparam int unsigned      K_DIV100 = 22;
    localparam longint unsigned  M_DIV100 = ((64'd1 << K_DIV100) + 64'd99) / 64'd100;
    localparam int unsigned      P_DIV100 = $clog2(M_DIV100 + 64'd1) + 15;

    localparam int unsigned      K_DIVERA = 40;
    localparam longint unsigned  M_DIVERA =
        ((64'd1 << K_DIVERA) + 64'(ERA_DAYS) - 64'd1) / 64'(ERA_DAYS);
    localparam int unsigned      P_DIVERA = $clog2(M_DIVERA + 64'd1) + 22;

    localparam int unsigned      K_DIV1460 = 29;
    localparam longint unsigned  M_DIV1460 = ((64'd1 << K_DIV1460) + 64'd1459) / 64'd1460;
    localparam int unsigned      P_DIV1460 = $clog2(M_DIV1460 + 64'd1) + 18;

    localparam int unsigned      K_DIV36524 = 34;
    localparam longint unsigned  M_DIV36524 =
        ((64'd1 << K_DIV36524) + 64'd36523) / 64'd36524;
    localparam int unsigned      P_DIV36524 = $clog2(M_DIV36524 + 64'd1) + 18;

    localparam int unsigned      K_DIV365 = 27;
    localparam longint unsigned  M_DIV365 = ((64'd1 << K_DIV365) + 64'd364) / 64'd365;
    localparam int unsigned      P_DIV365 = $clog2(M_DIV365 + 64'd1) + 18;

    localparam int unsigned      K_DIV153 = 20;
    localparam longint unsigned  M_DIV153 = ((64'd1 << K_DIV153) + 64'd152) / 64'd153;
    localparam int unsigned      P_DIV153 = $clog2(M_DIV153 + 64'd1) + 12;

    // Item state carried down the pipeline
    typedef struct packed {
        req_type_t             mode;
        logic [YEAR_W-1:0]     y_in;
        logic [MONTH_W-1:0]    m_in;
        logic [DAY_W-1:0]      d_in;
        logic [SERIAL_W-1:0]   s_in;
        logic                  bad1;     // serial out of range
        logic [14:0]           ys;       // shifted year, date path
        logic [3:0]            mp0;      // March-based month, date path
        logic [21:0]           z;        // biased serial, serial path
        logic [7:0]            q100;
        logic [22:0]           a0;
        logic [4:0]            era;
        logic [SERIAL_W-1:0]   s0;       // serial from date
        logic [17:0]           doe;
        logic [7:0]            q1460;
        logic [2:0]            q36524;
        logic                  c;
        logic [17:0]           t;
        logic [9:0]            yoe;
        logic [3:0]            yq100;
        logic [18:0]           yoe365;
        logic [YEAR_W-1:0]     ybase;
        logic [8:0]            doy;
        logic [3:0]            mp;
        logic [YEAR_W-1:0]     yr;       // final fields, both modes
        logic [MONTH_W-1:0]    mo;
        logic [DAY_W-1:0]      dy;
        logic [SERIAL_W-1:0]   s;
        logic [7:0]            q100f;
        logic [5:0]            wsum;
    } item_t;

    typedef struct packed {
        logic [SERIAL_W-1:0]   serial;
        logic [YEAR_W-1:0]     year;
        logic [MONTH_W-1:0]    month;
        logic [DAY_W-1:0]      day;
        logic [WDAY_W-1:0]     weekday;
        logic [MLEN_W-1:0]     mlen;
        logic                  leap;
        logic                  err;
    } res_t;

    function automatic logic [7:0] div100(input logic [14:0] x);
        logic [P_DIV100-1:0] p;
        p = P_DIV100'(x) * P_DIV100'(M_DIV100);
        return 8'(p >> K_DIV100);
    endfunction

    function automatic logic [4:0] div_era(input logic [21:0] x);
        logic [P_DIVERA-1:0] p;
        p = P_DIVERA'(x) * P_DIVERA'(M_DIVERA);
        return 5'(p >> K_DIVERA);
    endfunction

    function automatic logic [7:0] div1460(input logic [17:0] x);
        logic [P_DIV1460-1:0] p;
        p = P_DIV1460'(x) * P_DIV1460'(M_DIV1460);
        return 8'(p >> K_DIV1460);
    endfunction

    function automatic logic [2:0] div36524(input logic [17:0] x);
        logic [P_DIV36524-1:0] p;
        p = P_DIV36524'(x) * P_DIV36524'(M_DIV36524);
        return 3'(p >> K_DIV36524);
    endfunction

    function automatic logic [9:0] div365(input logic [17:0] x);
        logic [P_DIV365-1:0] p;
        p = P_DIV365'(x) * P_DIV365'(M_DIV365);
        return 10'(p >> K_DIV365);
    endfunction

    function automatic logic [4:0] div153(input logic [11:0] x);
        logic [P_DIV153-1:0] p;
        p = P_DIV153'(x) * P_DIV153'(M_DIV153);
        return 5'(p >> K_DIV153);
    endfunction

    // Days before a March-based month: (153 * mp + 2) / 5
    function automatic logic [8:0] cum_days(input logic [3:0] mp);
        logic [8:0] r;
        case (mp)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd92;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd153;
            4'd6:    r = 9'd184;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd245;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd306;
            4'd11:   r = 9'd337;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    function automatic logic [MLEN_W-1:0] month_days(input logic [MONTH_W-1:0] mo,
                                                     input logic leap);
        logic [MLEN_W-1:0] r;
        case (mo)
            4'd2:                             r = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:          r = 5'd30;
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8,
            4'd10, 4'd12:                     r = 5'd31;
            default:                          r = 5'd0;
        endcase
        return r;
    endfunction

    // Sum of octal digits; 8 == 1 mod 7, so the sum keeps the residue
    function automatic logic [5:0] octal_sum(input logic [SERIAL_W-1:0] v);
        logic [23:0] w;
        logic [5:0]  acc;
        w   = {1'b0, v};
        acc = '0;
        for (int i = 0; i < 8; i++) begin
            acc = acc + 6'(w[3*i +: 3]);
        end
        return acc;
    endfunction

    function automatic logic [WDAY_W-1:0] fold_mod7(input logic [5:0] x);
        logic [3:0] a;
        logic [2:0] b;
        a = 4'(x[5:3]) + 4'(x[2:0]);
        b = a[2:0] + 3'(a[3]);
        return (b == 3'd7) ? 3'd0 : b;
    endfunction

endpackage

/* sv/civil_date_serial_converter_core.sv */
// Civil date / serial day converter: 12-stage pipeline that takes one beat per
// cycle unless m_tready stalls the output and every stage is full. The serial-to-date
// path (era, year-of-era, day-of-year, month) sets the depth; stages hold
// constant-reciprocal multiplies and add/compare steps. aresetn (synchronous,
// active low) clears all stage valid bits; stage payload is not reset.
// Depends on cdsc_pkg and civil_date_serial_converter_core_defines.svh.
`include "civil_date_serial_converter_core_defines.svh"

module civil_date_serial_converter_core
    import cdsc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // year_in[13:0], month_in[17:14], day_in[22:18], serial_in[45:23], zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    // req_type[0]
    input  logic [0:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // serial_out[22:0], year_out[36:23], month_out[40:37], day_out[45:41],
    // weekday[48:46], month_length[53:49], leap_year[54], zero pad
    output logic [M_TDATA_W-1:0] m_tdata,
    // range_error[0]
    output logic [0:0]           m_tuser
);

    item_t             stg_reg  [1:NSTAGE-1];
    item_t             stg_next [1:NSTAGE-1];
    res_t              res_reg;
    res_t              res_next;
    logic [NSTAGE:1]   vld_reg;
    logic [NSTAGE:1]   vld_next;
    logic [NSTAGE:1]   adv;

    // Per-stage advance: a stage loads when empty or when its successor moves
    assign adv[NSTAGE] = !vld_reg[NSTAGE] || m_tready;
    for (genvar k = 1; k < NSTAGE; k++) begin : g_adv
        assign adv[k] = !vld_reg[k] || adv[k+1];
    end

    assign vld_next[1] = adv[1] ? s_tvalid : vld_reg[1];
    for (genvar k = 2; k <= NSTAGE; k++) begin : g_vld
        assign vld_next[k] = adv[k] ? vld_reg[k-1] : vld_reg[k];
    end

    // Stage logic
    always_comb begin
        item_t p;
        logic  leap;
        logic  bad0;
        logic  [YEAR_W-1:0]  r100;
        logic  [MLEN_W-1:0]  ml;
        logic  [3:0]         mo1;
        logic  [YEAR_W-1:0]  yr1;
        logic  [DAY_W-1:0]   dy1;

        // S1: unpack, shift year, bias serial, serial range check
        p      = '0;
        p.mode = req_type_t'(s_tuser[0]);
        p.y_in = s_tdata[13:0];
        p.m_in = s_tdata[17:14];
        p.d_in = s_tdata[22:18];
        p.s_in = s_tdata[45:23];
        p.bad1 = ($signed(p.s_in) < SERIAL_MIN) || ($signed(p.s_in) > SERIAL_MAX);
        p.ys   = 15'(p.y_in) - 15'(p.m_in <= 4'd2) + 15'd400;
        p.mp0  = (p.m_in > 4'd2) ? p.m_in - 4'd3 : p.m_in + 4'd9;
        p.z    = 22'(p.s_in + 23'(EPOCH_BIAS));
        stg_next[1] = p;

        // S2: year/100, linear day count, era of the serial
        p      = stg_reg[1];
        p.q100 = div100(p.ys);
        p.a0   = 23'(p.ys) * 23'd365 + 23'(p.ys >> 2) + 23'(cum_days(p.mp0))
               + 23'(p.d_in) - 23'd1;
        p.era  = div_era(p.z);
        stg_next[2] = p;

        // S3: finish date-to-serial; day of era
        p      = stg_reg[2];
        p.s0   = p.a0 - 23'(p.q100) + 23'(p.q100 >> 2) - 23'(EPOCH_BIAS);
        p.doe  = 18'(p.z - 22'(p.era) * 22'(ERA_DAYS));
        stg_next[3] = p;

        // S4: leap corrections within the era
        p        = stg_reg[3];
        p.q1460  = div1460(p.doe);
        p.q36524 = div36524(p.doe);
        p.c      = (p.doe == 18'(ERA_DAYS - 1));
        stg_next[4] = p;

        // S5
        p   = stg_reg[4];
        p.t = p.doe - 18'(p.q1460) + 18'(p.q36524) - 18'(p.c);
        stg_next[5] = p;

        // S6: year of era
        p     = stg_reg[5];
        p.yoe = div365(p.t);
        stg_next[6] = p;

        // S7: days before this year of era, base year
        p        = stg_reg[6];
        p.yq100  = 4'(div100(15'(p.yoe)));
        p.yoe365 = 19'(p.yoe) * 19'd365 + 19'(p.yoe >> 2);
        p.ybase  = 14'(p.yoe) + 14'(p.era) * 14'd400;
        stg_next[7] = p;

        // S8: day of year
        p     = stg_reg[7];
        p.doy = 9'(19'(p.doe) - p.yoe365 + 19'(p.yq100));
        stg_next[8] = p;

        // S9: March-based month
        p    = stg_reg[8];
        p.mp = 4'(div153(12'(p.doy) * 12'd5 + 12'd2));
        stg_next[9] = p;

        // S10: day, month, year; merge both request kinds
        p    = stg_reg[9];
        dy1  = 5'(p.doy - cum_days(p.mp) + 9'd1);
        mo1  = (p.mp < 4'd10) ? p.mp + 4'd3 : p.mp - 4'd9;
        yr1  = p.ybase - 14'd400 + 14'(mo1 <= 4'd2);
        if (p.mode == REQ_SERIAL_TO_DATE) begin
            p.yr = yr1;
            p.mo = mo1;
            p.dy = dy1;
            p.s  = p.s_in;
        end else begin
            p.yr = p.y_in;
            p.mo = p.m_in;
            p.dy = p.d_in;
            p.s  = p.s0;
        end
        stg_next[10] = p;

        // S11: century of final year, weekday digit sum
        p       = stg_reg[10];
        p.q100f = div100(15'(p.yr));
        p.wsum  = octal_sum(p.s + 23'(WDAY_BIAS));
        stg_next[11] = p;

        // S12: leap flag, month length, validity, zero on error
        p    = stg_reg[11];
        r100 = p.yr - 14'(p.q100f) * 14'd100;
        leap = (p.yr[1:0] == 2'd0) && ((r100 != '0) || (p.q100f[1:0] == 2'd0));
        ml   = month_days(p.mo, leap);
        bad0 = (p.yr > 14'(YEAR_MAX)) || !(p.mo inside {[4'd1:4'd12]})
            || (p.dy == '0) || (p.dy > ml);
        res_next = '0;
        if ((p.mode == REQ_SERIAL_TO_DATE) ? p.bad1 : bad0) begin
            res_next.err = 1'b1;
        end else begin
            res_next.serial  = p.s;
            res_next.year    = p.yr;
            res_next.month   = p.mo;
            res_next.day     = p.dy;
            res_next.weekday = fold_mod7(p.wsum);
            res_next.mlen    = ml;
            res_next.leap    = leap;
        end
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        for (int k = 1; k < NSTAGE; k++) begin
            if (adv[k]) begin
                stg_reg[k] <= stg_next[k];
            end
        end
        if (adv[NSTAGE]) begin
            res_reg <= res_next;
        end
    end

    assign s_tready = adv[1];
    assign m_tvalid = vld_reg[NSTAGE];
    assign m_tdata  = {1'b0, res_reg.leap, res_reg.mlen, res_reg.weekday, res_reg.day,
                       res_reg.month, res_reg.year, res_reg.serial};
    assign m_tuser  = res_reg.err;

    // Checks
    `CDSC_ASSERT_NOW(a_err_zeroes, aclk, aresetn, vld_reg[NSTAGE] && res_reg.err, (m_tdata == '0), "error result carries nonzero fields")
    `CDSC_ASSERT_NOW(a_date_sane, aclk, aresetn, vld_reg[NSTAGE] && !res_reg.err, (res_reg.month >= 4'd1) && (res_reg.month <= 4'd12) && (res_reg.day >= 5'd1) && (res_reg.day <= res_reg.mlen), "good result has impossible date")
    `CDSC_ASSERT_NOW(a_feb_leap, aclk, aresetn, vld_reg[NSTAGE] && !res_reg.err && (res_reg.month == 4'd2), (res_reg.mlen == (res_reg.leap ? 5'd29 : 5'd28)), "February length disagrees with leap flag")
    `CDSC_ASSERT_NEXT(a_mid_hold, aclk, aresetn, vld_reg[6] && !adv[6], vld_reg[6] && (stg_reg[6] == $past(stg_reg[6])), "stalled stage lost or changed its item")

endmodule
